// ===== src/owc_pkg.sv =====
// Shared widths, codes and state types of the obstacle window collision check.
package owc_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 24;

  localparam int RAD_W      = 16;
  localparam int CAP_W      = 11;
  localparam int STAMP_W    = 32;
  localparam int WIN_W      = 32;
  localparam int DIST_W     = 25;
  localparam int CLR_W      = RAD_W + 1;
  localparam int SQ_W       = 2 * CLR_W;
  localparam int D2_W       = SQ_W + 1;
  localparam int ROOT_W     = (D2_W + 1) / 2;
  localparam int OPND_W     = 2 * ROOT_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_CHECK = 2'd2,
    REQ_NOP   = 2'd3
  } req_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROBOT_RADIUS = CFG_IDX_W'(0),
    REG_INFLATION    = CFG_IDX_W'(1),
    REG_TIME_WINDOW  = CFG_IDX_W'(2),
    REG_CAPACITY     = CFG_IDX_W'(3)
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_COPY,
    ST_SCAN,
    ST_SQRT,
    ST_DONE
  } owc_state_t;

endpackage

// ===== src/owc_req_if.sv =====
// Request channel: request kind, point coordinates and stamp.
interface owc_req_if #(
  parameter int COORD_BITS = owc_pkg::COORD_BITS_DEF
);
  import owc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [STAMP_W-1:0]           stamp_ms;

  modport source (output valid, req_type, point_x, point_y, stamp_ms, input ready);
  modport sink   (input valid, req_type, point_x, point_y, stamp_ms, output ready);
endinterface

// ===== src/owc_res_if.sv =====
// Result channel: free flag, distance and stored point count.
interface owc_res_if #(
  parameter int MAX_POINTS = owc_pkg::MAX_POINTS_DEF
);
  import owc_pkg::*;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  logic              valid;
  logic              ready;
  logic              path_clear;
  logic [DIST_W-1:0] distance_mm;
  logic [CNT_W-1:0]  point_count;

  modport source (output valid, path_clear, distance_mm, point_count, input ready);
  modport sink   (input valid, path_clear, distance_mm, point_count, output ready);
endinterface

// ===== src/owc_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface owc_cfg_if;
  import owc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

// ===== src/owc_isqrt.sv =====
// Digit-by-digit floor square root, one result bit per cycle.
module owc_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [owc_pkg::D2_W-1:0]  radicand,
  output logic                      done,
  output logic [owc_pkg::ROOT_W-1:0] root
);
  import owc_pkg::*;

  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [OPND_W-1:0] opnd;
  logic [REM_W-1:0]  rem;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              take;

  assign rem_sh = {rem, opnd[OPND_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root, 2'b01});
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        opnd <= OPND_W'(radicand);
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        // bring down two bits, keep the digit when the trial fits
        rem  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root <= {root[ROOT_W-2:0], take};
        opnd <= {opnd[OPND_W-3:0], 2'b00};
        step <= step + 1'b1;
        if (step == STEP_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/obstacle_window_collision_check.sv =====
// Top level: obstacle point store with time-window pruning and clearance check.
//
//   channel  dir  handshake      beat carries
//   req      in   valid/ready    req_type, point_x, point_y, stamp_ms
//   rsp      out  valid/ready    path_clear, distance_mm, point_count
//   cfg      in   valid/ready    reg_index, reg_data (ready always high)
//
// One request at a time; the store is a single memory of MAX_POINTS+1 rows.
// Clear and the unused code go straight to the done state; add writes the point,
// then runs a prune copy pass when the window is on and an eviction copy pass
// when the store is over capacity. Check runs a pipelined scan, then the square
// root on a hit. The memory has a single read port and a single write port.
// Reset (rst, synchronous) empties the store; rows need no clearing pass.
// A result waiting on rsp holds the block in its done state until taken.
module obstacle_window_collision_check #(
  parameter int MAX_POINTS = owc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = owc_pkg::COORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  owc_req_if.sink   req,
  owc_res_if.source rsp,
  owc_cfg_if.sink   cfg
);
  import owc_pkg::*;

  localparam int AW     = $clog2(MAX_POINTS + 1);
  localparam int CNT_W  = AW;
  localparam int IW     = $clog2(MAX_POINTS + 2);
  localparam int DEPTH  = MAX_POINTS + 1;
  localparam int DW     = COORD_BITS + 1;
  localparam int CMP_W  = (DW > CLR_W) ? DW : CLR_W;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [STAMP_W-1:0]           stamp;
  } entry_t;

  // Configuration registers
  logic [RAD_W-1:0] robot_radius;
  logic [RAD_W-1:0] inflation_radius;
  logic [WIN_W-1:0] time_window;
  logic [CAP_W-1:0] capacity;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      robot_radius     <= '0;
      inflation_radius <= '0;
      time_window      <= '0;
      capacity         <= CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.reg_index))
        REG_ROBOT_RADIUS: robot_radius     <= cfg.reg_data[RAD_W-1:0];
        REG_INFLATION:    inflation_radius <= cfg.reg_data[RAD_W-1:0];
        REG_TIME_WINDOW:  time_window      <= cfg.reg_data[WIN_W-1:0];
        REG_CAPACITY:     capacity         <= cfg.reg_data[CAP_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Clearance and its square; user keeps config stable while a request runs
  logic [CLR_W-1:0] clearance;
  logic [SQ_W-1:0]  clear_sq;

  assign clearance = CLR_W'(robot_radius) + CLR_W'(inflation_radius);

  always_ff @(posedge clk) begin
    clear_sq <= clearance * clearance;
  end

  // Capacity clamped into 1..MAX_POINTS
  logic [CNT_W-1:0] cap_eff;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity) > 32'(MAX_POINTS)) begin
      cap_eff = CNT_W'(MAX_POINTS);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  // Point store
  entry_t          mem [DEPTH];
  entry_t          mem_rdata;
  entry_t          mem_wdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Control and datapath registers
  owc_state_t                   state;
  owc_state_t                   state_next;
  logic signed [COORD_BITS-1:0] req_x;
  logic signed [COORD_BITS-1:0] req_y;
  logic [STAMP_W-1:0]           req_stamp;
  logic [CNT_W-1:0]             count;
  logic [IW-1:0]                rd_idx;
  logic [IW-1:0]                wr_idx;
  logic [IW-1:0]                end_idx;
  logic                         rvalid;
  logic                         evict_mode;
  logic                         v2;
  logic                         v3;
  logic                         near2;
  logic [CLR_W-1:0]             ax;
  logic [CLR_W-1:0]             ay;
  logic [SQ_W-1:0]              sqx;
  logic [SQ_W-1:0]              sqy;
  logic [D2_W-1:0]              d2;
  logic                         res_free;
  logic [DIST_W-1:0]            res_dist;
  logic                         sq_start;
  logic                         sq_done;
  logic [ROOT_W-1:0]            sq_root;

  // Combinational helpers
  logic [IW-1:0]          n1;
  logic                   window_on;
  logic                   keep;
  logic                   copy_done;
  logic                   need_evict;
  logic signed [DW-1:0]   dx;
  logic signed [DW-1:0]   dy;
  logic [DW-1:0]          adx;
  logic [DW-1:0]          ady;
  logic                   near1;
  logic [D2_W-1:0]        scan_sum;
  logic                   hit;
  logic                   scan_done;
  logic                   out_free;

  assign n1         = IW'(count) + IW'(1);
  assign window_on  = time_window != '0;
  // keep entries with stamp >= stamp - window, exact and without wrap
  assign keep       = evict_mode ||
                      ((33'(mem_rdata.stamp) + 33'(time_window)) >= 33'(req_stamp));
  assign copy_done  = (rd_idx == end_idx) && !rvalid;
  assign need_evict = wr_idx > IW'(cap_eff);

  assign dx    = DW'(req_x) - DW'(mem_rdata.x);
  assign dy    = DW'(req_y) - DW'(mem_rdata.y);
  assign adx   = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ady   = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign near1 = (CMP_W'(adx) <= CMP_W'(clearance)) && (CMP_W'(ady) <= CMP_W'(clearance));

  assign scan_sum  = D2_W'(sqx) + D2_W'(sqy);
  assign hit       = v3 && (scan_sum <= D2_W'(clear_sq));
  assign scan_done = (rd_idx == end_idx) && !rvalid && !v2 && !v3;
  assign out_free  = !rsp.valid || rsp.ready;

  assign req.ready = (state == ST_IDLE);
  assign mem_raddr = rd_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = wr_idx[AW-1:0];
    mem_wdata  = mem_rdata;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          unique case (req_kind_t'(req.req_type))
            REQ_ADD:   state_next = ST_ADD;
            REQ_CHECK: state_next = ST_SCAN;
            REQ_CLEAR: state_next = ST_DONE;
            REQ_NOP:   state_next = ST_DONE;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_ADD: begin
        // append at the tail; the spare row takes it when the store is full
        mem_we              = 1'b1;
        mem_waddr           = count[AW-1:0];
        mem_wdata.x         = req_x;
        mem_wdata.y         = req_y;
        mem_wdata.stamp     = req_stamp;
        if (window_on || (n1 > IW'(cap_eff))) begin
          state_next = ST_COPY;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_COPY: begin
        mem_we = rvalid && keep;
        if (copy_done && (evict_mode || !need_evict)) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_SQRT;
        end else if (scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rvalid     <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      sq_start   <= 1'b0;
      evict_mode <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            req_x     <= req.point_x;
            req_y     <= req.point_y;
            req_stamp <= req.stamp_ms;
            rvalid    <= 1'b0;
            v2        <= 1'b0;
            v3        <= 1'b0;
            rd_idx    <= '0;
            end_idx   <= IW'(count);
            res_free  <= 1'b1;
            res_dist  <= '0;
            if (req_kind_t'(req.req_type) == REQ_CLEAR) begin
              count <= '0;
            end
          end
        end
        ST_ADD: begin
          wr_idx  <= '0;
          end_idx <= n1;
          if (window_on) begin
            evict_mode <= 1'b0;
            rd_idx     <= '0;
          end else begin
            evict_mode <= 1'b1;
            rd_idx     <= n1 - IW'(cap_eff);
            if (n1 <= IW'(cap_eff)) begin
              count <= CNT_W'(n1);
            end
          end
        end
        ST_COPY: begin
          // issue reads ahead, write kept rows behind them
          if (rd_idx != end_idx) begin
            rd_idx <= rd_idx + IW'(1);
            rvalid <= 1'b1;
          end else begin
            rvalid <= 1'b0;
          end
          if (rvalid && keep) begin
            wr_idx <= wr_idx + IW'(1);
          end
          if (copy_done) begin
            if (!evict_mode && need_evict) begin
              evict_mode <= 1'b1;
              rd_idx     <= wr_idx - IW'(cap_eff);
              end_idx    <= wr_idx;
              wr_idx     <= '0;
            end else begin
              count <= CNT_W'(wr_idx);
            end
          end
        end
        ST_SCAN: begin
          if (rd_idx != end_idx) begin
            rd_idx <= rd_idx + IW'(1);
            rvalid <= 1'b1;
          end else begin
            rvalid <= 1'b0;
          end
          // stage 1: box test; stage 2: squares; stage 3: sum and compare
          v2    <= rvalid;
          near2 <= near1;
          ax    <= CLR_W'(adx);
          ay    <= CLR_W'(ady);
          v3    <= v2 && near2;
          sqx   <= ax * ax;
          sqy   <= ay * ay;
          if (hit) begin
            d2       <= scan_sum;
            res_free <= 1'b0;
            sq_start <= 1'b1;
            rvalid   <= 1'b0;
            v2       <= 1'b0;
            v3       <= 1'b0;
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            res_dist <= DIST_W'(sq_root);
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      rsp.valid          <= 1'b1;
      rsp.path_clear     <= res_free;
      rsp.distance_mm    <= res_dist;
      rsp.point_count    <= count;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  owc_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (d2),
    .done     (sq_done),
    .root     (sq_root)
  );

  // The write pointer of a copy pass always trails the read pointer
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) && rvalid |-> wr_idx < rd_idx)
    else $error("copy pass write pointer caught up with read pointer");

  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_DONE))
    else $error("result raised outside done state");

  assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == ST_SQRT)
    else $error("square root finished outside its state");

  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != ST_IDLE)
    else $error("accepted request left block idle");

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("stored count beyond store size");

endmodule
